/* hdl/mbe_pkg.sv */
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, widths, reset values and helpers for the escape-time
// pixel colouring block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  // Field widths.
  localparam int COORD_W    = 16;
  localparam int Z_W        = 32;
  localparam int STEP_W     = 31;
  localparam int ITER_W     = 8;
  localparam int LIM_W      = 6;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Arithmetic widths.
  localparam int SQ_W       = 2 * Z_W;
  localparam int PROD_C_W   = COORD_W + STEP_W;
  localparam int CW         = 17;
  localparam int QUO_W      = PIX_W;
  localparam int DIV_N_W    = CW + QUO_W;
  localparam int DIV_CNT_W  = $clog2(QUO_W);

  localparam int FRAC_BITS_DEF = 25;
  localparam int ITER_BOUND    = 255;
  localparam logic [11:0] ITER_BOUND_L = 12'(ITER_BOUND);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_LIMIT = 3'd5;

  // Reset values.
  localparam logic [Z_W-1:0]    X_ORIGIN_RST     = -32'sd73819750;
  localparam logic [Z_W-1:0]    Y_ORIGIN_RST     = -32'sd40265318;
  localparam logic [STEP_W-1:0] X_STEP_RST       = 31'd100663;
  localparam logic [STEP_W-1:0] Y_STEP_RST       = 31'd100663;
  localparam logic [ITER_W-1:0] MAX_ITER_RST     = 8'd255;
  localparam logic [LIM_W-1:0]  ESCAPE_LIMIT_RST = 6'd25;

  localparam logic signed [SQ_W-1:0] Z_MAX_W = 64'sd2147483647;
  localparam logic signed [SQ_W-1:0] Z_MIN_W = -64'sd2147483648;

  typedef struct packed {
    logic [Z_W-1:0]    x_origin;
    logic [Z_W-1:0]    y_origin;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
    logic [ITER_W-1:0] max_iter;
    logic [LIM_W-1:0]  escape_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  typedef struct packed {
    logic  load_pixel;
    logic  scale;
    logic  origin;
    logic  square;
    logic  step;
    logic  finish;
    logic  prep;
    logic  div_load;
    logic  div_step;
    logic  store_colour;
    logic  load_result;
    chan_t ch;
  } ctl_cmd_t;

  typedef struct packed {
    logic escaped;
    logic at_limit;
  } dp_stat_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SQ_W-1:0] v);
    if (v > Z_MAX_W) begin
      sat_z = {1'b0, {(Z_W-1){1'b1}}};
    end else if (v < Z_MIN_W) begin
      sat_z = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      sat_z = v[Z_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/mbe_pixel_if.sv */
// ----------------------------------------------------------------------------
// mbe_pixel_if
// Pixel position channel: column and row with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbe_pixel_if;
  import mbe_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;

  modport source (output valid, column, row, input ready);
  modport sink (input valid, column, row, output ready);
endinterface

`default_nettype wire

/* hdl/mbe_colour_if.sv */
// ----------------------------------------------------------------------------
// mbe_colour_if
// Result channel: escape count and RGB levels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbe_colour_if;
  import mbe_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] escape_count;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source (output valid, escape_count, red, green, blue, input ready);
  modport sink (input valid, escape_count, red, green, blue, output ready);
endinterface

`default_nettype wire

/* hdl/mbe_cfg.sv */
// ----------------------------------------------------------------------------
// mbe_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
  output mbe_pkg::cfg_t                  cfg
);
  import mbe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin     <= X_ORIGIN_RST;
      cfg.y_origin     <= Y_ORIGIN_RST;
      cfg.x_step       <= X_STEP_RST;
      cfg.y_step       <= Y_STEP_RST;
      cfg.max_iter     <= MAX_ITER_RST;
      cfg.escape_limit <= ESCAPE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_ORIGIN:     cfg.x_origin     <= cfg_data[Z_W-1:0];
        REG_Y_ORIGIN:     cfg.y_origin     <= cfg_data[Z_W-1:0];
        REG_X_STEP:       cfg.x_step       <= cfg_data[STEP_W-1:0];
        REG_Y_STEP:       cfg.y_step       <= cfg_data[STEP_W-1:0];
        REG_MAX_ITER:     cfg.max_iter     <= cfg_data[ITER_W-1:0];
        REG_ESCAPE_LIMIT: cfg.escape_limit <= cfg_data[LIM_W-1:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/mbe_datapath.sv */
// ----------------------------------------------------------------------------
// mbe_datapath
// Coordinate mapping, z = z*z + c iteration unit, spectrum setup,
// shared restoring divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_datapath #(
  parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  mbe_pkg::cfg_t               cfg,
  input  mbe_pkg::ctl_cmd_t           cmd,
  output mbe_pkg::dp_stat_t           stat,
  input  logic [mbe_pkg::COORD_W-1:0] column,
  input  logic [mbe_pkg::COORD_W-1:0] row,
  output logic [mbe_pkg::PIX_W-1:0]   escape_count,
  output logic [mbe_pkg::PIX_W-1:0]   red,
  output logic [mbe_pkg::PIX_W-1:0]   green,
  output logic [mbe_pkg::PIX_W-1:0]   blue
);
  import mbe_pkg::*;

  logic [COORD_W-1:0]         col_q;
  logic [COORD_W-1:0]         row_q;
  logic [PROD_C_W-1:0]        pc_x;
  logic [PROD_C_W-1:0]        pc_y;
  logic signed [Z_W-1:0]      cx;
  logic signed [Z_W-1:0]      cy;
  logic signed [Z_W-1:0]      zx;
  logic signed [Z_W-1:0]      zy;
  logic signed [SQ_W-1:0]     sq_x;
  logic signed [SQ_W-1:0]     sq_y;
  logic signed [SQ_W-1:0]     pr_xy;
  logic [ITER_W-1:0]          k;
  logic [ITER_W-1:0]          count;
  logic [ITER_W-1:0]          n;
  logic [ITER_W-1:0]          den;

  logic signed [SQ_W-1:0]     xx;
  logic signed [SQ_W-1:0]     yy;
  logic signed [SQ_W-1:0]     xy2;
  logic signed [SQ_W-1:0]     thr;
  logic signed [SQ_W-1:0]     cx_w;
  logic signed [SQ_W-1:0]     cy_w;
  logic signed [SQ_W-1:0]     nx_w;
  logic signed [SQ_W-1:0]     ny_w;

  // Spectrum setup: t = 260*count, mK = K*den.
  logic [CW-1:0]              t;
  logic [CW-1:0]              m25, m50, m55, m60, m70, m105, m130, m200, m260;
  logic [CW-1:0]              sel_diff;
  logic [CW-1:0]              sel_den;

  logic [DIV_N_W-1:0]         rem;
  logic [DIV_N_W-1:0]         dsh;
  logic [QUO_W-1:0]           quo;
  logic [PIX_W-1:0]           r_q, g_q, b_q;

  assign n   = (12'(cfg.max_iter) > ITER_BOUND_L) ? ITER_BOUND_L[ITER_W-1:0] : cfg.max_iter;
  assign den = (n == '0) ? ITER_W'(1) : n;

  assign cx_w = $signed({{(SQ_W-Z_W){cfg.x_origin[Z_W-1]}}, cfg.x_origin})
              + $signed({{(SQ_W-PROD_C_W){1'b0}}, pc_x});
  assign cy_w = $signed({{(SQ_W-Z_W){cfg.y_origin[Z_W-1]}}, cfg.y_origin})
              + $signed({{(SQ_W-PROD_C_W){1'b0}}, pc_y});

  // Arithmetic shifts of signed products round toward minus infinity.
  assign xx   = sq_x >>> FRAC_BITS;
  assign yy   = sq_y >>> FRAC_BITS;
  assign xy2  = pr_xy >>> (FRAC_BITS - 1);
  assign thr  = $signed({{(SQ_W-LIM_W){1'b0}}, cfg.escape_limit} << FRAC_BITS);
  assign nx_w = xx - yy + $signed({{(SQ_W-Z_W){cx[Z_W-1]}}, cx});
  assign ny_w = xy2 + $signed({{(SQ_W-Z_W){cy[Z_W-1]}}, cy});

  // The squares held here belong to the latest z; the first z is zero and never escapes.
  assign stat.escaped  = (k != '0) && ((xx + yy) > thr);
  assign stat.at_limit = (k == n);

  // Piecewise-linear spectrum: each channel becomes floor(255*diff/divisor).
  // Flat segments use diff/divisor of 0/1 or 1/1.
  always_comb begin
    sel_diff = '0;
    sel_den  = CW'(1);
    case (cmd.ch)
      CH_RED: begin
        if (t < m55) begin
          sel_diff = m55 - t;
          sel_den  = m55;
        end else if (t < m130) begin
          sel_diff = '0;
        end else if (t < m200) begin
          sel_diff = t - m130;
          sel_den  = m70;
        end else begin
          sel_diff = CW'(1);
        end
      end
      CH_GREEN: begin
        if (t < m55) begin
          sel_diff = '0;
        end else if (t < m105) begin
          sel_diff = t - m55;
          sel_den  = m50;
        end else if (t < m200) begin
          sel_diff = CW'(1);
        end else if (t < m260) begin
          sel_diff = m260 - t;
          sel_den  = m60;
        end else begin
          sel_diff = '0;
        end
      end
      CH_BLUE: begin
        if (t < m105) begin
          sel_diff = CW'(1);
        end else if (t < m130) begin
          sel_diff = m130 - t;
          sel_den  = m25;
        end else begin
          sel_diff = '0;
        end
      end
      default: begin
        sel_diff = '0;
        sel_den  = CW'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      col_q <= column;
      row_q <= row;
    end
    if (cmd.scale) begin
      pc_x <= PROD_C_W'(col_q) * PROD_C_W'(cfg.x_step);
      pc_y <= PROD_C_W'(row_q) * PROD_C_W'(cfg.y_step);
    end
    if (cmd.origin) begin
      cx <= sat_z(cx_w);
      cy <= sat_z(cy_w);
      zx <= '0;
      zy <= '0;
      k  <= '0;
    end
    if (cmd.square) begin
      sq_x  <= SQ_W'(zx) * SQ_W'(zx);
      sq_y  <= SQ_W'(zy) * SQ_W'(zy);
      pr_xy <= SQ_W'(zx) * SQ_W'(zy);
    end
    if (cmd.step) begin
      zx <= sat_z(nx_w);
      zy <= sat_z(ny_w);
      k  <= k + ITER_W'(1);
    end
    if (cmd.finish) begin
      count <= stat.escaped ? (k - ITER_W'(1)) : k;
    end
    if (cmd.prep) begin
      t    <= CW'(count) * CW'(260);
      m25  <= CW'(den) * CW'(25);
      m50  <= CW'(den) * CW'(50);
      m55  <= CW'(den) * CW'(55);
      m60  <= CW'(den) * CW'(60);
      m70  <= CW'(den) * CW'(70);
      m105 <= CW'(den) * CW'(105);
      m130 <= CW'(den) * CW'(130);
      m200 <= CW'(den) * CW'(200);
      m260 <= CW'(den) * CW'(260);
    end
    if (cmd.div_load) begin
      rem <= ({{QUO_W{1'b0}}, sel_diff} << QUO_W) - {{QUO_W{1'b0}}, sel_diff};
      dsh <= {1'b0, sel_den, {(QUO_W-1){1'b0}}};
      quo <= '0;
    end
    if (cmd.div_step) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
    if (cmd.store_colour) begin
      case (cmd.ch)
        CH_RED:   r_q <= quo;
        CH_GREEN: g_q <= quo;
        CH_BLUE:  b_q <= quo;
        default:  b_q <= quo;
      endcase
    end
    if (cmd.load_result) begin
      escape_count <= count;
      red          <= r_q;
      green        <= g_q;
      blue         <= b_q;
    end
  end

endmodule

`default_nettype wire

/* hdl/mbe_ctrl.sv */
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: pixel intake, iteration loop, three divider passes and the
// output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mbe_pkg::dp_stat_t stat,
  output mbe_pkg::ctl_cmd_t cmd
);
  import mbe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_ORIGIN,
    S_SQUARE,
    S_CHECK,
    S_PREP,
    S_LOAD,
    S_DIVIDE,
    S_STORE,
    S_DONE
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] cnt;
  chan_t                ch;
  logic                 done_go;

  assign in_ready = (state == S_IDLE);
  assign done_go  = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    cmd              = '0;
    cmd.ch           = ch;
    cmd.load_pixel   = (state == S_IDLE) && in_valid;
    cmd.scale        = (state == S_SCALE);
    cmd.origin       = (state == S_ORIGIN);
    cmd.square       = (state == S_SQUARE);
    cmd.finish       = (state == S_CHECK) && (stat.escaped || stat.at_limit);
    cmd.step         = (state == S_CHECK) && !(stat.escaped || stat.at_limit);
    cmd.prep         = (state == S_PREP);
    cmd.div_load     = (state == S_LOAD);
    cmd.div_step     = (state == S_DIVIDE);
    cmd.store_colour = (state == S_STORE);
    cmd.load_result  = done_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ch        <= CH_RED;
      out_valid <= 1'b0;
    end else begin
      // A new result may be loaded in the same cycle as the old one leaves.
      if (done_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCALE;
          end
        end
        S_SCALE:  state <= S_ORIGIN;
        S_ORIGIN: state <= S_SQUARE;
        S_SQUARE: state <= S_CHECK;
        S_CHECK: begin
          if (stat.escaped || stat.at_limit) begin
            state <= S_PREP;
          end else begin
            state <= S_SQUARE;
          end
        end
        S_PREP: begin
          ch    <= CH_RED;
          state <= S_LOAD;
        end
        S_LOAD: begin
          cnt   <= '0;
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          cnt <= cnt + DIV_CNT_W'(1);
          if (cnt == DIV_CNT_W'(QUO_W - 1)) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          case (ch)
            CH_RED: begin
              ch    <= CH_GREEN;
              state <= S_LOAD;
            end
            CH_GREEN: begin
              ch    <= CH_BLUE;
              state <= S_LOAD;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (done_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/mandelbrot_escape_pixel_colour.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_colour
// Escape-time iteration for one pixel, with spectrum colouring of the count.
// ----------------------------------------------------------------------------
// Usage:
//   The pixel channel takes one beat per pixel (column, row). The position maps
//   to c = origin + index * step in signed fixed point, and z = z*z + c runs
//   from zero until |z|^2 passes escape_limit or the iteration limit is hit.
//   The colour channel returns one beat per pixel: the escape count and the
//   8-bit red, green and blue levels of the matching spectrum wavelength.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write it
//   only while no pixel is in flight.
//
//   One pixel is worked at a time. Each z update runs through S_SQUARE, which
//   registers the three 32x32 products, and then S_CHECK, which does the add,
//   saturate and escape compare. A point that escapes takes escape_count + 1
//   updates, one that does not takes the limit. The colour stage then makes
//   three passes of an 8-step restoring divider shared by the channels. The
//   next pixel beat is taken in the cycle after a result is loaded.
//   Reset restores the default view registers and empties the block; it is
//   ready for a pixel as soon as reset is released. The result sits in an
//   output register, so a new pixel is accepted while the colour receiver
//   stalls; the next result waits in the sequencer until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_pixel_colour #(
  parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
  mbe_pixel_if.sink                      pixel,
  mbe_colour_if.source                   colour
);
  import mbe_pkg::*;

  cfg_t     cfg;
  ctl_cmd_t cmd;
  dp_stat_t stat;

  // View and limit registers.
  mbe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The sequencer owns both handshakes and the output valid flag.
  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (colour.valid),
    .out_ready (colour.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the payload of the result beat.
  mbe_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .column       (pixel.column),
    .row          (pixel.row),
    .escape_count (colour.escape_count),
    .red          (colour.red),
    .green        (colour.green),
    .blue         (colour.blue)
  );

endmodule

`default_nettype wire
